// ===== hw/rtl/hdg_pkg.sv =====
// ----------------------------------------------------------------------------
// Hypersphere direction generator package
// Shared constants and fixed-point helpers for the direction generator.
// ----------------------------------------------------------------------------
`default_nettype none

package hdg_pkg;

  localparam int unsigned DefaultMaxDims = 8;
  localparam logic [3:0]  DimsReset      = 4'd3;
  localparam logic [17:0] Q16One         = 18'sd65536;

  // Quarter-wave sine polynomial coefficients, unsigned Q30.
  localparam logic [30:0] PolyC1  = 31'd1686629713;
  localparam logic [30:0] PolyC3  = 31'd693598669;
  localparam logic [30:0] PolyC5  = 31'd85569306;
  localparam logic [30:0] PolyC7  = 31'd5026995;
  localparam logic [30:0] PolyC9  = 31'd172272;
  localparam logic [30:0] PolyC11 = 31'd3864;

  // Item passed from the front end to the back end.
  typedef struct packed {
    logic [16:0] phase;
    logic [2:0]  first_index;
    logic        last;
  } hdg_job_t;

endpackage : hdg_pkg

`default_nettype wire

// ===== hw/rtl/hdg_front.sv =====
// ----------------------------------------------------------------------------
// Direction generator front end
// Accepts fractions, decides which angle they are, and builds the phase.
// ----------------------------------------------------------------------------
`default_nettype none

module hdg_front #(
  parameter int unsigned MaxDims = hdg_pkg::DefaultMaxDims
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [3:0]       cfg_wdata_i,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [15:0]      angle_fraction_i,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output hdg_pkg::hdg_job_t     job_o
);

  localparam int unsigned CntW = $clog2(MaxDims);

  logic [3:0]      dims_q;
  logic [CntW-1:0] count_q, count_d;
  logic [4:0]      dims_eff;
  logic            last;
  logic            accept;

  // Clamp the dimension register to its working range.
  always_comb begin
    if (dims_q < 4'd2) begin
      dims_eff = 5'd2;
    end else if ({1'b0, dims_q} > 5'(MaxDims)) begin
      dims_eff = 5'(MaxDims);
    end else begin
      dims_eff = {1'b0, dims_q};
    end
  end

  assign last     = ({{(5 > CntW ? 5 - CntW : 1){1'b0}}, count_q} >= (dims_eff - 5'd2));
  assign full_o   = ~job_ready_i;
  assign accept   = push_i & job_ready_i;
  assign count_d  = last ? '0 : count_q + 1'b1;

  assign job_valid_o          = accept;
  assign job_o.phase          = last ? {angle_fraction_i, 1'b0} : {1'b0, angle_fraction_i};
  assign job_o.first_index    = last ? 3'(dims_eff - 5'd2) : 3'(count_q);
  assign job_o.last           = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= hdg_pkg::DimsReset;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        dims_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

endmodule : hdg_front

`default_nettype wire

// ===== hw/rtl/hdg_queue.sv =====
// ----------------------------------------------------------------------------
// Direction generator job queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hdg_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire hdg_pkg::hdg_job_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output hdg_pkg::hdg_job_t  rd_data_o
);

  hdg_pkg::hdg_job_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr = wr_valid_i & wr_ready_o;
  assign rd = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count slip");

endmodule : hdg_queue

`default_nettype wire

// ===== hw/rtl/hdg_back.sv =====
// ----------------------------------------------------------------------------
// Direction generator back end
// Sequencer evaluating sines and products with one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module hdg_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  output logic                   job_ready_o,
  input  wire hdg_pkg::hdg_job_t job_i,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic signed [17:0]     coordinate_o,
  output logic [2:0]             coordinate_index_o,
  output logic                   vector_end_o
);

  typedef enum logic [3:0] {
    StIdle, StSq, StHorner, StFinal, StRound, StMulC, StMulS, StOut1, StOut2
  } state_e;

  state_e      state_q;
  logic        sel_q;        // 0: polynomial at r, 1: at quarter - r
  logic [2:0]  step_q;
  logic [15:0] r_q;
  logic [1:0]  quad_q;
  logic [15:0] t_q;          // polynomial argument, up to 2^15
  logic [30:0] t2_q;         // square of the argument, up to 2^30
  logic [30:0] acc_q;
  logic [16:0] qa_q, qb_q;   // quarter sines
  logic [16:0] prod_q;       // magnitude of running product
  logic        pneg_q;
  logic        last_q;
  logic [2:0]  idx_q;
  logic signed [17:0] c_out_q, s_out_q;
  logic signed [17:0] s_q;
  logic        full_q;
  logic signed [17:0] coord_q;
  logic [2:0]  cidx_q;
  logic        cend_q;

  // Shared multiplier operands and result.
  logic [30:0] m_a;
  logic [30:0] m_b;
  logic [61:0] m_p;
  assign m_p = m_a * m_b;

  logic [30:0] coef;
  always_comb begin
    case (step_q)
      3'd0:    coef = hdg_pkg::PolyC9;
      3'd1:    coef = hdg_pkg::PolyC7;
      3'd2:    coef = hdg_pkg::PolyC5;
      3'd3:    coef = hdg_pkg::PolyC3;
      default: coef = hdg_pkg::PolyC1;
    endcase
  end

  // Sine and cosine with signs from quadrant.
  logic signed [17:0] sa, sb, sin_v, cos_v;
  assign sa = $signed({1'b0, qa_q});
  assign sb = $signed({1'b0, qb_q});
  always_comb begin
    unique case (quad_q)
      2'd0:    begin sin_v = sa;  cos_v = sb;  end
      2'd1:    begin sin_v = sb;  cos_v = -sa; end
      2'd2:    begin sin_v = -sa; cos_v = -sb; end
      default: begin sin_v = -sb; cos_v = sa;  end
    endcase
  end

  logic [16:0] mag_c, mag_s;
  assign mag_c = cos_v[17] ? 17'(-cos_v) : 17'(cos_v);
  assign mag_s = sin_v[17] ? 17'(-sin_v) : 17'(sin_v);

  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (state_q)
      StSq:     begin m_a = {15'd0, t_q}; m_b = {15'd0, t_q}; end
      StHorner: begin m_a = acc_q; m_b = t2_q; end
      StFinal:  begin m_a = acc_q; m_b = {15'd0, t_q}; end
      StMulC:   begin m_a = {14'd0, prod_q}; m_b = {14'd0, mag_c}; end
      StMulS:   begin m_a = {14'd0, prod_q}; m_b = {14'd0, mag_s}; end
      default:  begin m_a = '0; m_b = '0; end
    endcase
  end

  logic [16:0] sine_rnd;
  logic [33:0] sine_full;
  assign sine_full = 34'((m_p + 62'd268435456) >> 29);
  assign sine_rnd  = (sine_full > 34'd65536) ? 17'd65536 : sine_full[16:0];

  logic [16:0] qmag;
  logic [34:0] qfull;
  assign qfull = 35'((m_p + 62'd32768) >> 16);
  assign qmag  = (qfull > 35'd65536) ? 17'd65536 : qfull[16:0];

  logic signed [17:0] qsigned_c, qsigned_s;
  assign qsigned_c = (pneg_q ^ cos_v[17]) ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign qsigned_s = (pneg_q ^ sin_v[17]) ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  assign job_ready_o = (state_q == StIdle);
  assign empty_o     = ~full_q;
  assign coordinate_o       = coord_q;
  assign coordinate_index_o = cidx_q;
  assign vector_end_o       = cend_q;

  logic pop;
  assign pop = pop_i & full_q;

  // A component enters the output register when it is free or being taken.
  logic emit;
  assign emit = ((state_q == StOut1) || (state_q == StOut2)) && (!full_q || pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      full_q  <= 1'b0;
      prod_q  <= 17'd65536;
      pneg_q  <= 1'b0;
      sel_q   <= 1'b0;
      step_q  <= '0;
    end else begin
      if (emit) begin
        full_q <= 1'b1;
      end else if (pop) begin
        full_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            quad_q <= job_i.phase[16:15];
            r_q    <= {1'b0, job_i.phase[14:0]};
            t_q    <= {1'b0, job_i.phase[14:0]};
            idx_q  <= job_i.first_index;
            last_q <= job_i.last;
            sel_q  <= 1'b0;
            state_q <= StSq;
          end
        end
        StSq: begin
          t2_q   <= m_p[30:0];
          acc_q  <= hdg_pkg::PolyC11;
          step_q <= '0;
          state_q <= StHorner;
        end
        StHorner: begin
          acc_q <= coef - 31'(m_p >> 30);
          if (step_q == 3'd4) state_q <= StFinal;
          step_q <= step_q + 3'd1;
        end
        StFinal: begin
          if (!sel_q) begin
            qa_q  <= sine_rnd;
            sel_q <= 1'b1;
            t_q   <= 16'd32768 - r_q;
            state_q <= StSq;
          end else begin
            qb_q <= sine_rnd;
            state_q <= StMulC;
          end
        end
        StMulC: begin
          c_out_q <= qsigned_c;
          state_q <= StMulS;
        end
        StMulS: begin
          s_q <= qsigned_s;
          state_q <= StOut1;
        end
        StOut1: begin
          if (!full_q || pop) begin
            coord_q <= c_out_q;
            cidx_q  <= idx_q;
            cend_q  <= 1'b0;
            if (last_q) begin
              state_q <= StOut2;
            end else begin
              prod_q  <= s_q[17] ? 17'(-s_q) : 17'(s_q);
              pneg_q  <= s_q[17];
              state_q <= StIdle;
            end
          end
        end
        StOut2: begin
          if (!full_q || pop) begin
            coord_q <= s_q;
            cidx_q  <= idx_q + 3'd1;
            cend_q  <= 1'b1;
            prod_q  <= 17'd65536;
            pneg_q  <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_prod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_q <= 17'd65536) else $error("product magnitude out of range");
  a_end_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut2 && (!full_q || pop)) |=> (cend_q && full_q))
    else $error("vector end not shown");
  a_reset_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut2 && (!full_q || pop)) |=> prod_q == 17'd65536)
    else $error("product not reset after vector");

endmodule : hdg_back

`default_nettype wire

// ===== hw/rtl/hypersphere_direction_generator.sv =====
// ----------------------------------------------------------------------------
// Hypersphere direction generator
// Turns uniform random fractions into the components of unit step vectors.
// ----------------------------------------------------------------------------
// Input channel: drive angle_fraction_i and push_i; an item is taken at a
// clock edge where push_i is high and full_o is low. Each item is one angle.
// The front end decides whether the angle is the last of its vector and
// places a job into a two-entry queue, so it keeps taking items while the
// back end works.
// Output channel: while empty_o is low, coordinate_o, coordinate_index_o
// and vector_end_o show the oldest component; pop_i takes it.
// The back end shares one multiplier for two polynomial sine evaluations
// (seven products each) and two Q1.16 products. A job runs through StSq,
// StHorner and StFinal for each sine, then StMulC, StMulS and StOut1, where
// its first component enters the output register. The back end takes no new
// job until it returns to StIdle. A last angle gives two components; the
// second one enters the output at the edge where the first is taken.
// If the receiver stalls, the back end holds its component and waits; the
// queue then fills and full_o rises.
// Reset sets dimensions to three, the running sine product to one and the
// angle count to zero. Write dimensions via cfg_we_i while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module hypersphere_direction_generator #(
  parameter int unsigned MaxDims = hdg_pkg::DefaultMaxDims
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [3:0]        cfg_wdata_i,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic [15:0]       angle_fraction_i,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic signed [17:0]     coordinate_o,
  output logic [2:0]             coordinate_index_o,
  output logic                   vector_end_o
);

  hdg_pkg::hdg_job_t fe_job, be_job;
  logic fe_valid, fe_ready, be_valid, be_ready;

  // Front end: angle bookkeeping and phase scaling.
  hdg_front #(.MaxDims(MaxDims)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push_i, .full_o,
    .angle_fraction_i,
    .job_valid_o(fe_valid), .job_ready_i(fe_ready), .job_o(fe_job)
  );

  // Queue decouples classification from arithmetic.
  hdg_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fe_valid), .wr_ready_o(fe_ready), .wr_data_i(fe_job),
    .rd_valid_o(be_valid), .rd_ready_i(be_ready), .rd_data_o(be_job)
  );

  // Back end: sines, products and output register.
  hdg_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(be_valid), .job_ready_o(be_ready), .job_i(be_job),
    .empty_o, .pop_i, .coordinate_o, .coordinate_index_o, .vector_end_o
  );

endmodule : hypersphere_direction_generator

`default_nettype wire
